// ----- hdl/uv_sphere_mesh_generator_unit_macros.svh -----
// assertion macros for the uv sphere mesh generator
`ifndef UV_SPHERE_MESH_GENERATOR_UNIT_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define UVS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("uvs assertion failed");
// next-cycle implication
`define UVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("uvs assertion failed");
`else
`define UVS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define UVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hdl/uvs_pkg.sv -----
// shared types, constants and the arctangent table of the uv sphere generator
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

  localparam int CNT_W      = 9;
  localparam int QUO_W      = 33;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 8;
  localparam int ANG_W      = 32;
  localparam int TRIG_W     = 32;
  localparam int CORDIC_W   = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_QUAD   = 1'b1
  } req_kind_e;

  typedef enum logic [2:0] {
    REG_RADIUS      = 3'd0,
    REG_CENTRE_X    = 3'd1,
    REG_CENTRE_Y    = 3'd2,
    REG_CENTRE_Z    = 3'd3,
    REG_SLICE_COUNT = 3'd4,
    REG_STACK_COUNT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [16:0] base;
  } side_t;

  // arctangent of 2^-i in binary angle units, 2^32 per turn
  function automatic logic [ANG_W-1:0] atan_turn(input int idx);
    logic [ANG_W-1:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/uvs_fdiv.sv -----
// pipelined fractional divider, quotient floor(num * 2^32 / den) for num <= den
`timescale 1ns / 1ps
`default_nettype none
module uvs_fdiv (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [uvs_pkg::CNT_W-1:0]   num_i,
  input  logic [uvs_pkg::CNT_W-1:0]   den_i,
  output logic [uvs_pkg::QUO_W-1:0]   quo_o
);

  localparam int RW = uvs_pkg::CNT_W;
  localparam int QW = uvs_pkg::QUO_W;

  logic [RW-1:0] rem_q [uvs_pkg::DIV_STAGES];
  logic [QW-1:0] quo_q [uvs_pkg::DIV_STAGES];

  for (genvar s = 0; s < uvs_pkg::DIV_STAGES; s++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [RW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (s == 0) begin : g_first
      // integer bit first
      always_comb begin
        if (num_i >= den_i) begin
          rem_in = num_i - den_i;
          quo_in = QW'(1);
        end else begin
          rem_in = num_i;
          quo_in = '0;
        end
      end
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [RW:0]   wide;
      logic [RW-1:0] r;
      logic [QW-1:0] q;
      r = rem_in;
      q = quo_in;
      for (int j = 0; j < uvs_pkg::DIV_STEPS; j++) begin
        wide = {r, 1'b0};
        if (wide >= {1'b0, den_i}) begin
          wide = wide - {1'b0, den_i};
          q    = {q[QW-2:0], 1'b1};
        end else begin
          q    = {q[QW-2:0], 1'b0};
        end
        r = wide[RW-1:0];
      end
      rem_d = r;
      quo_d = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[uvs_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- hdl/uvs_cordic.sv -----
// pipelined rotation cordic, one iteration per stage, sine and cosine in q.30
`timescale 1ns / 1ps
`default_nettype none
module uvs_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [uvs_pkg::ANG_W-1:0]          ang_i,
  output logic signed [uvs_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [uvs_pkg::TRIG_W-1:0]  cos_o
);

  localparam int W  = uvs_pkg::CORDIC_W;
  localparam int AW = uvs_pkg::ANG_W;

  logic signed [W-1:0] x_q [ITERATIONS];
  logic signed [W-1:0] y_q [ITERATIONS];
  logic signed [W-1:0] z_q [ITERATIONS];
  logic                flip_q [ITERATIONS];
  logic signed [uvs_pkg::TRIG_W-1:0] sin_q, cos_q;

  for (genvar s = 0; s < ITERATIONS; s++) begin : g_iter
    logic signed [W-1:0] x_in, y_in, z_in, x_d, y_d, z_d;
    logic                flip_in;

    if (s == 0) begin : g_fold
      // fold into [-1/4, 1/4) turn, results negated on a fold
      always_comb begin
        logic [AW-1:0] quarter, folded;
        quarter = ang_i + 32'h4000_0000;
        flip_in = quarter[AW-1];
        folded  = flip_in ? ang_i + 32'h8000_0000 : ang_i;
        z_in    = W'(signed'(folded));
        x_in    = uvs_pkg::CORDIC_GAIN;
        y_in    = '0;
      end
    end else begin : g_chain
      assign x_in    = x_q[s-1];
      assign y_in    = y_q[s-1];
      assign z_in    = z_q[s-1];
      assign flip_in = flip_q[s-1];
    end

    always_comb begin
      logic signed [W-1:0] dx, dy, at;
      dx = y_in >>> s;
      dy = x_in >>> s;
      at = W'(uvs_pkg::atan_turn(s));
      if (!z_in[W-1]) begin
        x_d = x_in - dx;
        y_d = y_in + dy;
        z_d = z_in - at;
      end else begin
        x_d = x_in + dx;
        y_d = y_in - dy;
        z_d = z_in + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]    <= x_d;
        y_q[s]    <= y_d;
        z_q[s]    <= z_d;
        flip_q[s] <= flip_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= uvs_pkg::TRIG_W'(flip_q[ITERATIONS-1] ? -x_q[ITERATIONS-1] : x_q[ITERATIONS-1]);
      sin_q <= uvs_pkg::TRIG_W'(flip_q[ITERATIONS-1] ? -y_q[ITERATIONS-1] : y_q[ITERATIONS-1]);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

// ----- hdl/uv_sphere_mesh_generator_unit.sv -----
// top level of the uv sphere mesh generator: request pipeline and output stage
`timescale 1ns / 1ps
`default_nettype none
// Generates one grid point of a latitude-longitude sphere per request. A vertex
// request returns position (q.8, saturated), unit normal (q1.14) and texcoords
// (q1.16); a quad request returns the cell's two index triangles, the second
// marked last. Out-of-range requests are taken and give no result. A request
// enters every cycle unless stalled and passes 8 divider stages of 4 quotient
// bits, ANGLE_ITERATIONS + 1 cordic stages, 3 multiply/round stages and the
// output register. Vertex results stream at one per cycle unless the output
// stalls; a quad holds the output register for two transfers, stalling input.
// Registers are written only while the block is idle: the user's rule, unchecked here.
`include "uv_sphere_mesh_generator_unit_macros.svh"
module uv_sphere_mesh_generator_unit #(
  parameter int MAX_SLICES       = 256,
  parameter int MAX_STACKS       = 256,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  // requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [8:0]         stack_index_i,
  input  logic [7:0]         slice_index_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] pos_x_o,
  output logic signed [23:0] pos_y_o,
  output logic signed [23:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [16:0]        corner_a_o,
  output logic [16:0]        corner_b_o,
  output logic [16:0]        corner_c_o,
  output logic               last_o
);

  // stage counts: divider, cordic plus negate stage, three multiply stages
  localparam int PIPE_DEPTH = uvs_pkg::DIV_STAGES + ANGLE_ITERATIONS + 4;
  localparam int TEX_DEPTH  = ANGLE_ITERATIONS + 4;

  // configuration registers
  logic [15:0]        radius_q;
  logic signed [23:0] centre_x_q, centre_y_q, centre_z_q;
  logic [8:0]         slice_count_q, stack_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= 16'd256;
      centre_x_q    <= '0;
      centre_y_q    <= '0;
      centre_z_q    <= '0;
      slice_count_q <= 9'd16;
      stack_count_q <= 9'd16;
    end else if (cfg_valid_i) begin
      case (uvs_pkg::cfg_reg_e'(cfg_index_i))
        uvs_pkg::REG_RADIUS:      radius_q      <= cfg_data_i[15:0];
        uvs_pkg::REG_CENTRE_X:    centre_x_q    <= cfg_data_i;
        uvs_pkg::REG_CENTRE_Y:    centre_y_q    <= cfg_data_i;
        uvs_pkg::REG_CENTRE_Z:    centre_z_q    <= cfg_data_i;
        uvs_pkg::REG_SLICE_COUNT: slice_count_q <= cfg_data_i[8:0];
        uvs_pkg::REG_STACK_COUNT: stack_count_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // clamped grid size, to be held static by the user while requests are in flight
  logic [8:0] slices, slices_m1, stacks;

  always_comb begin
    if (slice_count_q < 9'd2) begin
      slices = 9'd2;
    end else if (32'(slice_count_q) > MAX_SLICES) begin
      slices = 9'(MAX_SLICES);
    end else begin
      slices = slice_count_q;
    end
    if (stack_count_q < 9'd1) begin
      stacks = 9'd1;
    end else if (32'(stack_count_q) > MAX_STACKS) begin
      stacks = 9'(MAX_STACKS);
    end else begin
      stacks = stack_count_q;
    end
  end

  assign slices_m1 = slices - 9'd1;

  // handshake: the whole pipeline moves when the output register frees up
  logic              adv;
  logic              out_valid_q, out_second_q;
  uvs_pkg::req_kind_e out_kind_q;

  assign adv = !out_valid_q ||
               (!out_stall_i && (out_kind_q == uvs_pkg::KIND_VERTEX || out_second_q));
  assign in_stall_o = !adv;

  // range check; rejected requests simply never get a valid bit
  logic in_ok;
  logic [8:0] slice_ext;
  assign slice_ext = {1'b0, slice_index_i};

  always_comb begin
    if (uvs_pkg::req_kind_e'(kind_i) == uvs_pkg::KIND_QUAD) begin
      in_ok = (stack_index_i < stacks) && (slice_ext < slices_m1);
    end else begin
      in_ok = (stack_index_i <= stacks) && (slice_ext < slices);
    end
  end

  uvs_pkg::side_t side_in;
  assign side_in.kind = uvs_pkg::req_kind_e'(kind_i);
  assign side_in.base = 17'(stack_index_i) * 17'(slices) + 17'(slice_index_i);

  // angle and texcoord divisions, all floor(n * 2^32 / d)
  logic [uvs_pkg::QUO_W-1:0] q_th, q_ph, q_tu, q_tv;

  uvs_fdiv u_div_theta (
    .clk_i (clk_i), .en_i (adv),
    .num_i (stack_index_i), .den_i (stacks), .quo_o (q_th)
  );

  uvs_fdiv u_div_phi (
    .clk_i (clk_i), .en_i (adv),
    .num_i (slice_ext), .den_i (slices_m1), .quo_o (q_ph)
  );

  uvs_fdiv u_div_tex_u (
    .clk_i (clk_i), .en_i (adv),
    .num_i (slices_m1 - slice_ext), .den_i (slices_m1), .quo_o (q_tu)
  );

  uvs_fdiv u_div_tex_v (
    .clk_i (clk_i), .en_i (adv),
    .num_i (stacks - stack_index_i), .den_i (stacks), .quo_o (q_tv)
  );

  // theta is half a turn scale, phi wraps so the seam lands on angle zero
  logic signed [uvs_pkg::TRIG_W-1:0] st, ct, sp, cp;

  uvs_cordic #(.ITERATIONS (ANGLE_ITERATIONS)) u_cordic_theta (
    .clk_i (clk_i), .en_i (adv), .ang_i (q_th[32:1]), .sin_o (st), .cos_o (ct)
  );

  uvs_cordic #(.ITERATIONS (ANGLE_ITERATIONS)) u_cordic_phi (
    .clk_i (clk_i), .en_i (adv), .ang_i (q_ph[31:0]), .sin_o (sp), .cos_o (cp)
  );

  // sideband and delay lines
  logic [PIPE_DEPTH-1:0] vld_q;
  uvs_pkg::side_t        side_q [PIPE_DEPTH];
  logic [16:0]           texu_q [TEX_DEPTH];
  logic [16:0]           texv_q [TEX_DEPTH];

  // multiply and round stages
  logic signed [63:0] m1_x_q, m1_z_q;
  logic signed [31:0] m1_y_q;
  logic signed [32:0] m2_x_q, m2_y_q, m2_z_q;
  logic signed [49:0] m3_x_q, m3_y_q, m3_z_q;
  logic signed [15:0] m3_nx_q, m3_ny_q, m3_nz_q;
  logic signed [16:0] radius_s;

  assign radius_s = signed'({1'b0, radius_q});

  function automatic logic signed [15:0] to_norm(input logic signed [32:0] u);
    logic signed [33:0] t;
    t = (34'(u) + 34'sd32768) >>> 16;
    if (t > 34'sd16384) begin
      t = 34'sd16384;
    end else if (t < -34'sd16384) begin
      t = -34'sd16384;
    end
    return 16'(t);
  endfunction

  function automatic logic signed [23:0] to_pos(input logic signed [49:0] p,
                                                input logic signed [23:0] c);
    logic signed [50:0] r;
    logic signed [25:0] s;
    r = (51'(p) + 51'sd536870912) >>> 30;
    s = 26'(r) + 26'(c);
    if (s > 26'sd8388607) begin
      s = 26'sd8388607;
    end else if (s < -26'sd8388608) begin
      s = -26'sd8388608;
    end
    return 24'(s);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i && in_ok};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        side_q[k] <= side_q[k-1];
      end
      texu_q[0] <= q_tu[32:16];
      texv_q[0] <= q_tv[32:16];
      for (int k = 1; k < TEX_DEPTH; k++) begin
        texu_q[k] <= texu_q[k-1];
        texv_q[k] <= texv_q[k-1];
      end
      // direction x and z are cos/sin(phi) scaled by sin(theta)
      m1_x_q  <= cp * st;
      m1_z_q  <= sp * st;
      m1_y_q  <= ct;
      m2_x_q  <= 33'((m1_x_q + 64'sd536870912) >>> 30);
      m2_z_q  <= 33'((m1_z_q + 64'sd536870912) >>> 30);
      m2_y_q  <= 33'(m1_y_q);
      m3_x_q  <= radius_s * m2_x_q;
      m3_y_q  <= radius_s * m2_y_q;
      m3_z_q  <= radius_s * m2_z_q;
      m3_nx_q <= to_norm(m2_x_q);
      m3_ny_q <= to_norm(m2_y_q);
      m3_nz_q <= to_norm(m2_z_q);
    end
  end

  // output register; a quad stays for a second transfer
  uvs_pkg::side_t     side_top;
  logic signed [23:0] out_px_q, out_py_q, out_pz_q;
  logic signed [15:0] out_nx_q, out_ny_q, out_nz_q;
  logic [16:0]        out_tu_q, out_tv_q;
  logic [16:0]        out_ca_q, out_cb_q, out_cc_q;

  assign side_top = side_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_second_q <= 1'b0;
    end else if (adv) begin
      out_valid_q  <= vld_q[PIPE_DEPTH-1];
      out_second_q <= 1'b0;
    end else if (out_valid_q && !out_stall_i) begin
      // first half of a quad has gone
      out_second_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_kind_q <= side_top.kind;
      if (side_top.kind == uvs_pkg::KIND_QUAD) begin
        out_px_q <= '0;
        out_py_q <= '0;
        out_pz_q <= '0;
        out_nx_q <= '0;
        out_ny_q <= '0;
        out_nz_q <= '0;
        out_tu_q <= '0;
        out_tv_q <= '0;
        out_ca_q <= 17'(side_top.base + 17'(slices));
        out_cb_q <= 17'(side_top.base + 17'd1);
        out_cc_q <= side_top.base;
      end else begin
        out_px_q <= to_pos(m3_x_q, centre_x_q);
        out_py_q <= to_pos(m3_y_q, centre_y_q);
        out_pz_q <= to_pos(m3_z_q, centre_z_q);
        out_nx_q <= m3_nx_q;
        out_ny_q <= m3_ny_q;
        out_nz_q <= m3_nz_q;
        out_tu_q <= texu_q[TEX_DEPTH-1];
        out_tv_q <= texv_q[TEX_DEPTH-1];
        out_ca_q <= '0;
        out_cb_q <= '0;
        out_cc_q <= '0;
      end
    end else if (out_valid_q && !out_stall_i) begin
      // second triangle: top-left, top-right, bottom-right
      out_cb_q <= 17'(out_ca_q + 17'd1);
      out_cc_q <= out_cb_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_px_q;
  assign pos_y_o     = out_py_q;
  assign pos_z_o     = out_pz_q;
  assign norm_x_o    = out_nx_q;
  assign norm_y_o    = out_ny_q;
  assign norm_z_o    = out_nz_q;
  assign tex_u_o     = out_tu_q;
  assign tex_v_o     = out_tv_q;
  assign corner_a_o  = out_ca_q;
  assign corner_b_o  = out_cb_q;
  assign corner_c_o  = out_cc_q;
  assign last_o      = (out_kind_q == uvs_pkg::KIND_VERTEX) || out_second_q;

  // a taken first quad result is always followed by its second
  `UVS_ASSERT_NEXT(a_quad_pair, clk_i, rst_ni, out_valid_q && !out_stall_i && out_kind_q == uvs_pkg::KIND_QUAD && !out_second_q, out_valid_q && out_second_q)
  // the pipeline holds while the first quad result is pending
  `UVS_ASSERT_NOW(a_quad_hold, clk_i, rst_ni, out_valid_q && out_kind_q == uvs_pkg::KIND_QUAD && !out_second_q, in_stall_o)
  // rejected requests never enter the pipeline
  `UVS_ASSERT_NEXT(a_drop_bad, clk_i, rst_ni, in_valid_i && !in_stall_o && !in_ok, !vld_q[0])
  // second triangle shares the next column
  `UVS_ASSERT_NOW(a_second_tri, clk_i, rst_ni, out_valid_q && out_kind_q == uvs_pkg::KIND_QUAD && out_second_q, out_cb_q == 17'(out_ca_q + 17'd1))

endmodule
`default_nettype wire
